@@ hdl/pot_index_pulse_zeroing_top_defines.svh @@
// Assertion macros for the checker of the zeroing estimator.
`ifndef POT_INDEX_PULSE_ZEROING_TOP_DEFINES_SVH
`define POT_INDEX_PULSE_ZEROING_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PIPZ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PIPZ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pipz_pkg.sv @@
// Types, constants and helpers shared by the zeroing estimator modules.
`default_nettype none
package pipz_pkg;

   // field widths
   localparam int POS_W        = 32;
   localparam int PULSE_W      = 32;
   localparam int OP_W         = 2;
   localparam int FILTER_LEN_W = 6;
   localparam int SPACING_W    = 31;
   localparam int DRIFT_W      = 31;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;

   // stream widths
   localparam int REQ_TDATA_W  = 128;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 64;
   localparam int RSP_TUSER_W  = 2;

   // wide working value for sums ahead of saturation
   localparam int SAT_W        = 38;
   // numerator width of the snap division: 2*|n| + spacing
   localparam int SNAP_NUM_W   = 35;

   localparam int MAX_FILTER_DEF = 32;

   // register reset values
   localparam logic [FILTER_LEN_W-1:0] FILTER_LEN_RST = FILTER_LEN_W'(8);
   localparam logic [SPACING_W-1:0]    SPACING_RST    = SPACING_W'(65536);
   localparam logic [DRIFT_W-1:0]      DRIFT_RST      = DRIFT_W'(32768);

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE      = 2'd0,
      OP_FORCE_ERROR = 2'd1,
      OP_RESTART     = 2'd2,
      OP_NONE        = 2'd3
   } pipz_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_LENGTH   = 2'd0,
      CSR_INDEX_SPACING   = 2'd1,
      CSR_INDEX_REFERENCE = 2'd2,
      CSR_DRIFT_LIMIT     = 2'd3
   } pipz_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RETIRE,
      ST_ADD,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_DECIDE,
      ST_SNAP_N,
      ST_SNAP_MAG,
      ST_SNAP_GO,
      ST_SNAP_WAIT,
      ST_SNAP_FIX,
      ST_SNAP_SAT,
      ST_DRIFT,
      ST_EMIT
   } pipz_state_type;

   // clamp a wide signed value into the Q16.16 position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'({1'b0, {(POS_W-1){1'b1}}});
      lo = -hi - SAT_W'(1);
      if (v > hi) begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return v[POS_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ hdl/pot_index_pulse_zeroing_top.sv @@
// Pot and index pulse zeroing estimator: top level with sequencer and state.
//
// Each request item carries a sample (pot, encoder, latched encoder, pulse
// count) or a command (force error, restart, no-op); every item yields exactly
// one response item. A sample goes through the shared bit-serial divider,
// which runs twice: once for the ring average and once for the index grid
// snap. Samples that do not snap finish after the first division; commands
// skip the divider. req_tready is high only between items, while the response
// register lets a finished item wait for rsp_tready. Configuration writes take
// effect at once and are meant for idle periods; writing the filter length
// restarts the average.
`default_nettype none
module pot_index_pulse_zeroing_top #(
   parameter int MAX_FILTER = pipz_pkg::MAX_FILTER_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request: tdata = pot_value, encoder_value, latched_value, pulse_count
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [pipz_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // request: tuser = operation
   input  wire logic [pipz_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // response: tdata = position_out, filtered_out
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [pipz_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // response: tuser = zeroed_flag, error_flag
   output logic      [pipz_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [pipz_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pipz_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pipz_pkg::*;

   localparam int SLOT_W    = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
   localparam int CNT_W     = $clog2(MAX_FILTER + 1);
   localparam int SUM_W     = POS_W + $clog2(MAX_FILTER);
   localparam int DIV_NUM_W = (SUM_W > SNAP_NUM_W) ? SUM_W : SNAP_NUM_W;
   localparam int DIV_DEN_W = POS_W;

   // sequencer
   pipz_state_type state_ff, state_in;

   // configuration registers
   logic        [FILTER_LEN_W-1:0] filter_len_ff, filter_len_in;
   logic        [SPACING_W-1:0]    spacing_ff, spacing_in;
   logic signed [POS_W-1:0]        ref_ff, ref_in;
   logic        [DRIFT_W-1:0]      drift_ff, drift_in;

   // estimator state
   logic        [CNT_W-1:0]   fill_ff, fill_in;
   logic        [SLOT_W-1:0]  slot_ff, slot_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [POS_W-1:0]   offset_ff, offset_in;
   logic signed [POS_W-1:0]   first_ff, first_in;
   logic        [PULSE_W-1:0] last_pulse_ff, last_pulse_in;
   logic                      awaiting_ff, awaiting_in;
   logic                      zeroed_ff, zeroed_in;
   logic                      error_ff, error_in;

   // item being worked on
   pipz_op_type               op_ff, op_in;
   logic signed [POS_W-1:0]   enc_ff, enc_in;
   logic signed [POS_W-1:0]   lat_ff, lat_in;
   logic        [PULSE_W-1:0] pulses_ff, pulses_in;
   logic signed [POS_W-1:0]   sample_ff, sample_in;
   logic signed [POS_W-1:0]   avg_ff, avg_in;
   logic signed [SAT_W-1:0]   t_ff, t_in;
   logic                      neg_ff, neg_in;
   logic [DIV_NUM_W-1:0]      num_ff, num_in;
   logic [DIV_DEN_W-1:0]      den_ff, den_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic signed [POS_W-1:0]   rsp_filt_ff, rsp_filt_in;
   logic                      rsp_zeroed_ff, rsp_zeroed_in;
   logic                      rsp_error_ff, rsp_error_in;

   // helpers
   logic                      accept;
   logic                      emit_ok;
   logic                      keep_avg;
   logic                      do_snap;
   logic [CNT_W-1:0]          eff_len;
   logic [SPACING_W-1:0]      spacing_eff;
   logic [CNT_W:0]            slot_next;
   logic [SUM_W-1:0]          sum_mag;
   logic signed [POS_W-1:0]   req_pot;
   logic signed [POS_W-1:0]   req_enc;
   logic signed [POS_W-1:0]   snap_cand;
   logic signed [POS_W+1:0]   drift_d;
   logic signed [POS_W+1:0]   drift_s;
   logic signed [POS_W-1:0]   ring_rdata;

   // shared unit and ring controls
   logic                      div_start;
   logic [DIV_NUM_W-1:0]      div_num;
   logic [DIV_DEN_W-1:0]      div_den;
   logic                      div_done;
   logic [DIV_NUM_W-1:0]      div_quo;
   logic [DIV_DEN_W-1:0]      div_rem;
   logic                      ring_we;

   assign req_pot = req_tdata[POS_W-1:0];
   assign req_enc = req_tdata[2*POS_W-1:POS_W];
   assign accept  = req_tvalid && req_tready;
   assign emit_ok = !rsp_valid_ff || rsp_tready;

   // effective filter length and index spacing
   always_comb begin
      if (filter_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (int'(filter_len_ff) > MAX_FILTER) begin
         eff_len = CNT_W'(MAX_FILTER);
      end else begin
         eff_len = CNT_W'(filter_len_ff);
      end
      spacing_eff = (spacing_ff == '0) ? SPACING_W'(1) : spacing_ff;
   end

   assign slot_next = {1'b0, CNT_W'(slot_ff)} + (CNT_W + 1)'(1);
   assign sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign keep_avg  = !zeroed_ff && ((pulses_ff == last_pulse_ff) || (fill_ff < eff_len));
   assign do_snap   = !zeroed_ff || (pulses_ff != last_pulse_ff);
   assign snap_cand = sat_pos(t_ff - SAT_W'(lat_ff));
   assign drift_d   = (POS_W + 2)'(first_ff) - (POS_W + 2)'(offset_ff);
   assign drift_s   = (POS_W + 2)'(drift_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (pipz_op_type'(req_tuser) == OP_SAMPLE) ? ST_RETIRE : ST_EMIT;
            end
         end
         ST_RETIRE:   state_in = ST_ADD;
         ST_ADD:      state_in = ST_AVG_GO;
         ST_AVG_GO:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!keep_avg && do_snap) begin
               state_in = ST_SNAP_N;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SNAP_N:    state_in = ST_SNAP_MAG;
         ST_SNAP_MAG:  state_in = ST_SNAP_GO;
         ST_SNAP_GO:   state_in = ST_SNAP_WAIT;
         ST_SNAP_WAIT: begin
            if (div_done) begin
               state_in = ST_SNAP_FIX;
            end
         end
         ST_SNAP_FIX:  state_in = ST_SNAP_SAT;
         ST_SNAP_SAT:  state_in = ST_DRIFT;
         ST_DRIFT:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      ring_we    = 1'b0;
      div_num    = num_ff;
      div_den    = den_ff;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_ADD:     ring_we    = 1'b1;
         ST_AVG_GO: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(sum_mag);
            div_den   = DIV_DEN_W'(fill_ff);
         end
         ST_SNAP_GO: div_start  = 1'b1;
         default: begin
         end
      endcase
   end

   // datapath and estimator state
   always_comb begin
      filter_len_in = filter_len_ff;
      spacing_in    = spacing_ff;
      ref_in        = ref_ff;
      drift_in      = drift_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      sum_in        = sum_ff;
      offset_in     = offset_ff;
      first_in      = first_ff;
      last_pulse_in = last_pulse_ff;
      awaiting_in   = awaiting_ff;
      zeroed_in     = zeroed_ff;
      error_in      = error_ff;
      op_in         = op_ff;
      enc_in        = enc_ff;
      lat_in        = lat_ff;
      pulses_in     = pulses_ff;
      sample_in     = sample_ff;
      avg_in        = avg_ff;
      t_in          = t_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_filt_in   = rsp_filt_ff;
      rsp_zeroed_in = rsp_zeroed_ff;
      rsp_error_in  = rsp_error_ff;

      case (state_ff)
         // take the item; commands act on the state here
         ST_IDLE: begin
            if (accept) begin
               op_in     = pipz_op_type'(req_tuser);
               enc_in    = req_enc;
               lat_in    = req_tdata[3*POS_W-1:2*POS_W];
               pulses_in = req_tdata[3*POS_W+PULSE_W-1:3*POS_W];
               sample_in = sat_pos(SAT_W'(req_pot) - SAT_W'(req_enc));
               case (pipz_op_type'(req_tuser))
                  OP_FORCE_ERROR: error_in = 1'b1;
                  OP_RESTART: begin
                     fill_in       = '0;
                     slot_in       = '0;
                     sum_in        = '0;
                     offset_in     = '0;
                     first_in      = '0;
                     last_pulse_in = '0;
                     awaiting_in   = 1'b1;
                     zeroed_in     = 1'b0;
                     error_in      = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // note the first pulse count; count the fill, or drop the oldest sample once the ring is full
         ST_RETIRE: begin
            if (awaiting_ff) begin
               last_pulse_in = pulses_ff;
               awaiting_in   = 1'b0;
            end
            if (fill_ff < eff_len) begin
               fill_in = fill_ff + CNT_W'(1);
            end else begin
               sum_in = sum_ff - SUM_W'(ring_rdata);
            end
         end
         // add the new sample and advance the slot
         ST_ADD: begin
            sum_in  = sum_ff + SUM_W'(sample_ff);
            slot_in = (slot_next >= {1'b0, eff_len}) ? '0 : SLOT_W'(slot_next);
         end
         // average, truncated toward zero
         ST_AVG_WAIT: begin
            if (div_done) begin
               avg_in = sum_ff[SUM_W-1] ? -POS_W'(div_quo) : POS_W'(div_quo);
            end
         end
         ST_DECIDE: begin
            if (keep_avg) begin
               offset_in = avg_ff;
            end
            t_in = SAT_W'(avg_ff) + SAT_W'(lat_ff);
         end
         // distance from the reference index
         ST_SNAP_N: t_in = t_ff - SAT_W'(ref_ff);
         // 2*|n| + s over 2*s gives the rounded grid count
         ST_SNAP_MAG: begin
            neg_in = t_ff[SAT_W-1];
            num_in = t_ff[SAT_W-1] ?
                     DIV_NUM_W'(SAT_W'(spacing_eff) - (t_ff <<< 1)) :
                     DIV_NUM_W'((t_ff <<< 1) + SAT_W'(spacing_eff));
            den_in = DIV_DEN_W'({spacing_eff, 1'b0});
         end
         // count times spacing is (num - rem) / 2
         ST_SNAP_WAIT: begin
            if (div_done) begin
               num_in = (num_ff - DIV_NUM_W'(div_rem)) >> 1;
            end
         end
         ST_SNAP_FIX: begin
            t_in = neg_ff ? SAT_W'(ref_ff) - SAT_W'(num_ff) : SAT_W'(ref_ff) + SAT_W'(num_ff);
         end
         ST_SNAP_SAT: begin
            offset_in     = snap_cand;
            last_pulse_in = pulses_ff;
            zeroed_in     = 1'b1;
            if (!zeroed_ff) begin
               first_in = snap_cand;
            end
         end
         // sticky drift check against the first snapped offset
         ST_DRIFT: begin
            if ((drift_d > drift_s) || (drift_d < -drift_s)) begin
               error_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_zeroed_in = zeroed_ff;
               rsp_error_in  = error_ff;
               if (op_ff == OP_SAMPLE) begin
                  rsp_pos_in  = sat_pos(SAT_W'(offset_ff) + SAT_W'(enc_ff));
                  rsp_filt_in = sat_pos(SAT_W'(avg_ff) + SAT_W'(enc_ff));
               end else begin
                  rsp_pos_in  = '0;
                  rsp_filt_in = '0;
               end
            end
         end
         default: begin
         end
      endcase

      // register writes; the filter length restarts the average
      if (csr_we) begin
         unique case (pipz_csr_type'(csr_index))
            CSR_FILTER_LENGTH: begin
               filter_len_in = csr_wdata[FILTER_LEN_W-1:0];
               fill_in       = '0;
               slot_in       = '0;
               sum_in        = '0;
            end
            CSR_INDEX_SPACING:   spacing_in = csr_wdata[SPACING_W-1:0];
            CSR_INDEX_REFERENCE: ref_in     = csr_wdata[POS_W-1:0];
            CSR_DRIFT_LIMIT:     drift_in   = csr_wdata[DRIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control and estimator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         filter_len_ff <= FILTER_LEN_RST;
         spacing_ff    <= SPACING_RST;
         ref_ff        <= '0;
         drift_ff      <= DRIFT_RST;
         fill_ff       <= '0;
         slot_ff       <= '0;
         sum_ff        <= '0;
         offset_ff     <= '0;
         first_ff      <= '0;
         last_pulse_ff <= '0;
         awaiting_ff   <= 1'b1;
         zeroed_ff     <= 1'b0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         filter_len_ff <= filter_len_in;
         spacing_ff    <= spacing_in;
         ref_ff        <= ref_in;
         drift_ff      <= drift_in;
         fill_ff       <= fill_in;
         slot_ff       <= slot_in;
         sum_ff        <= sum_in;
         offset_ff     <= offset_in;
         first_ff      <= first_in;
         last_pulse_ff <= last_pulse_in;
         awaiting_ff   <= awaiting_in;
         zeroed_ff     <= zeroed_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item payload and response data
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      enc_ff        <= enc_in;
      lat_ff        <= lat_in;
      pulses_ff     <= pulses_in;
      sample_ff     <= sample_in;
      avg_ff        <= avg_in;
      t_ff          <= t_in;
      neg_ff        <= neg_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_filt_ff   <= rsp_filt_in;
      rsp_zeroed_ff <= rsp_zeroed_in;
      rsp_error_ff  <= rsp_error_in;
   end

   pipz_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   pipz_ring #(
      .DEPTH  (MAX_FILTER),
      .ADDR_W (SLOT_W),
      .DATA_W (POS_W)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (slot_ff),
      .wdata (sample_ff),
      .raddr (slot_ff),
      .rdata (ring_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_filt_ff, rsp_pos_ff};
   assign rsp_tuser  = {rsp_error_ff, rsp_zeroed_ff};
endmodule
`default_nettype wire

@@ hdl/pipz_div.sv @@
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module pipz_div #(
   parameter int NUM_W = 37,
   parameter int DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo,
   output logic      [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   // one shift-and-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

@@ hdl/pipz_ring.sv @@
// Sample ring: one write port, one registered read port.
`default_nettype none
module pipz_ring #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ hdl/pipz_checker.sv @@
// Port-level checks of the zeroing estimator, bound to the top level.
`default_nettype none
`include "pot_index_pulse_zeroing_top_defines.svh"
module pipz_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [pipz_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic [pipz_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import pipz_pkg::*;

   logic       req_take;
   logic       rsp_take;
   logic [1:0] pending_ff, pending_in;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // items taken in but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // one item at a time: busy right after taking one
   `PIPZ_ASSERT_NXT(a_busy_after_take, req_take, !req_tready, "ready right after an item")

   // a held response does not change
   `PIPZ_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while held")

   // no response without an item to answer
   `PIPZ_ASSERT_IMP(a_rsp_has_item, rsp_tvalid, pending_ff != 2'd0, "response without an item")

   // before zeroing the offset is the average, so both outputs agree
   `PIPZ_ASSERT_IMP(a_unzeroed_match, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[POS_W-1:0] == rsp_tdata[2*POS_W-1:POS_W], "position differs before zeroing")
endmodule

bind pot_index_pulse_zeroing_top pipz_checker u_pipz_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

@@ dv/tb_pot_index_pulse_zeroing_top.sv @@
// Self-checking stream testbench for the pot and index pulse zeroing estimator.
module tb_pot_index_pulse_zeroing_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pipz_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PHASE_ITEMS  = 220;
   localparam int DRAIN_CYCLES = 200;
   localparam int REPORT_CAP   = 100;
   localparam int HOLD_CYCLES  = 700;

   // one response item as the block should present it
   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic signed [POS_W-1:0] filtered;
      logic                    zeroed;
      logic                    err;
   } position_report_type;

   // mirror of the estimator state plus the queue of pending responses
   class zeroing_scoreboard;
      logic [FILTER_LEN_W-1:0] len_reg;
      logic [SPACING_W-1:0]    spacing_reg;
      logic signed [POS_W-1:0] ref_reg;
      logic [DRIFT_W-1:0]      drift_reg;

      longint                  ring [MAX_FILTER_DEF];
      int unsigned             fill;
      int unsigned             slot;
      longint                  sum;
      longint                  offset;
      longint                  first_off;
      logic [PULSE_W-1:0]      last_pulses;
      bit                      awaiting;
      bit                      zeroed;
      bit                      err;

      position_report_type     expected_reports [$];
      int                      failures;
      int                      checked;
      int                      snaps;
      int                      zeroed_seen;
      int                      error_seen;
      int                      op_count [4];

      function new();
         len_reg     = FILTER_LEN_RST;
         spacing_reg = SPACING_RST;
         ref_reg     = '0;
         drift_reg   = DRIFT_RST;
         restart_estimate();
         failures    = 0;
         checked     = 0;
         snaps       = 0;
         zeroed_seen = 0;
         error_seen  = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function longint clamp_q16(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function int unsigned effective_length();
         if (len_reg == 0) return 1;
         if (len_reg > MAX_FILTER_DEF) return MAX_FILTER_DEF;
         return len_reg;
      endfunction

      function void clear_average();
         fill = 0;
         slot = 0;
         sum  = 0;
      endfunction

      function void restart_estimate();
         foreach (ring[i]) ring[i] = 0;
         clear_average();
         offset      = 0;
         first_off   = 0;
         last_pulses = '0;
         awaiting    = 1'b1;
         zeroed      = 1'b0;
         err         = 1'b0;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void write_reg(pipz_csr_type which, logic [CSR_DATA_W-1:0] value);
         case (which)
            CSR_FILTER_LENGTH: begin
               len_reg = value[FILTER_LEN_W-1:0];
               clear_average();
            end
            CSR_INDEX_SPACING:   spacing_reg = value[SPACING_W-1:0];
            CSR_INDEX_REFERENCE: ref_reg = value;
            CSR_DRIFT_LIMIT:     drift_reg = value[DRIFT_W-1:0];
            default: ;
         endcase
      endfunction

      // nearest grid point, half away from zero, turned back into an offset
      function longint snap_to_index(longint avg, longint lat);
         longint s;
         longint n;
         longint mag;
         longint q;
         s   = (spacing_reg == '0) ? 64'sd1 : longint'(spacing_reg);
         n   = avg + lat - longint'(ref_reg);
         mag = (n < 0) ? -n : n;
         q   = (2 * mag + s) / (2 * s);
         if (n < 0) q = -q;
         return clamp_q16(q * s - lat + longint'(ref_reg));
      endfunction

      // work out the response to one accepted request item
      function void note_item(pipz_op_type op, logic [POS_W-1:0] pot, logic [POS_W-1:0] enc,
                              logic [POS_W-1:0] lat, logic [PULSE_W-1:0] pulses);
         position_report_type want;
         longint              enc_v;
         longint              lat_v;
         longint              sample;
         longint              avg;
         longint              drift;
         int unsigned         len;
         want = '0;
         op_count[op]++;
         case (op)
            OP_FORCE_ERROR: err = 1'b1;
            OP_RESTART:     restart_estimate();
            OP_SAMPLE: begin
               enc_v  = longint'(signed'(enc));
               lat_v  = longint'(signed'(lat));
               len    = effective_length();
               sample = clamp_q16(longint'(signed'(pot)) - enc_v);
               if (awaiting) begin
                  last_pulses = pulses;
                  awaiting    = 1'b0;
               end
               // ring update with running sum
               if (fill < len) begin
                  fill++;
               end else begin
                  sum -= ring[slot];
               end
               sum       += sample;
               ring[slot] = sample;
               slot       = (slot + 1 >= len) ? 0 : slot + 1;
               avg        = sum / longint'(fill);
               // averaging until full and pulsed, then snap on every new pulse
               if (!zeroed && (pulses == last_pulses || fill < len)) begin
                  offset = avg;
               end else if (!zeroed || pulses != last_pulses) begin
                  offset      = snap_to_index(avg, lat_v);
                  last_pulses = pulses;
                  snaps++;
                  if (!zeroed) first_off = offset;
                  zeroed = 1'b1;
                  drift  = first_off - offset;
                  if (drift < 0) drift = -drift;
                  if (drift > longint'(drift_reg)) err = 1'b1;
               end
               want.position = POS_W'(clamp_q16(offset + enc_v));
               want.filtered = POS_W'(clamp_q16(avg + enc_v));
            end
            default: ;
         endcase
         want.zeroed = zeroed;
         want.err    = err;
         expected_reports.insert(expected_reports.size(), want);
      endfunction

      function void compare_field(string name, logic signed [POS_W-1:0] want,
                                  logic signed [POS_W-1:0] got);
         if (got !== want) begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      // compare one accepted response item with the oldest prediction
      function void check_result(logic [RSP_TDATA_W-1:0] data, logic [RSP_TUSER_W-1:0] flags);
         position_report_type want;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= REPORT_CAP)
               $error("response item arrived with no request item outstanding");
         end else begin
            want = expected_reports.pop_front();
            checked++;
            if (flags[0] === 1'b1) zeroed_seen++;
            if (flags[1] === 1'b1) error_seen++;
            compare_field("position_out", want.position, data[POS_W-1:0]);
            compare_field("filtered_out", want.filtered, data[2*POS_W-1:POS_W]);
            compare_field("zeroed_flag", want.zeroed, flags[0]);
            compare_field("error_flag", want.err, flags[1]);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic [REQ_TUSER_W-1:0]   req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [RSP_TUSER_W-1:0]   rsp_tuser;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int                       tx_idle_pct = 0;
   int                       rx_stall_pct = 0;
   int                       hold_len = 0;
   int                       hold_left = 0;
   bit                       hold_toggle = 1'b0;
   bit                       hold_seen = 1'b0;
   int                       cycle_count = 0;

   zeroing_scoreboard        board = new();

   pot_index_pulse_zeroing_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   // offer one item, wait for the handshake, then predict its response
   task automatic send_item(pipz_op_type op, logic [POS_W-1:0] pot, logic [POS_W-1:0] enc,
                            logic [POS_W-1:0] lat, logic [PULSE_W-1:0] pulses);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pulses, lat, enc, pot};
      do @(posedge clock); while (!req_tready);
      board.note_item(op, pot, enc, lat, pulses);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // all four registers, back to back
   task automatic write_settings(logic [CSR_DATA_W-1:0] len, logic [CSR_DATA_W-1:0] spacing,
                                 logic [CSR_DATA_W-1:0] refpos, logic [CSR_DATA_W-1:0] drift);
      pipz_csr_type          which [4];
      logic [CSR_DATA_W-1:0] value [4];
      which = '{CSR_FILTER_LENGTH, CSR_INDEX_SPACING, CSR_INDEX_REFERENCE, CSR_DRIFT_LIMIT};
      value = '{len, spacing, refpos, drift};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= which[i];
         csr_wdata <= value[i];
         @(posedge clock);
         board.write_reg(which[i], value[i]);
      end
      csr_we <= 1'b0;
   endtask

   // a moving axis: pot tracks encoder plus a fixed offset, pulses now and then,
   // with forced errors, restarts, no-ops and wild samples mixed in
   task automatic run_track(int count, bit fresh);
      int          enc;
      int          off;
      int          pot;
      int          lat;
      int          k;
      int          roll;
      int unsigned pulses;
      off    = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      enc    = int'($urandom);
      pulses = $urandom;
      lat    = int'($urandom);
      k      = int'($urandom_range(0, 2));
      if (fresh) send_item(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_item(OP_FORCE_ERROR, $urandom, $urandom, $urandom, $urandom);
         end else if (roll < 5) begin
            send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);
         end else if (roll < 8) begin
            send_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom);
         end else if (roll < 9) begin
            send_item(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
         end else begin
            enc = enc + int'($urandom_range(0, 32'h3FFF)) - 32'sh2000;
            pot = enc + off + int'($urandom_range(0, 255)) - 128;
            // new pulse: latched value sits near a grid point, sometimes one over
            if ($urandom_range(5) == 0) begin
               pulses = pulses + 1;
               if ($urandom_range(3) == 0) k = k + int'($urandom_range(0, 2)) - 1;
               lat = board.ref_reg - off + k * int'(board.spacing_reg)
                     + int'($urandom_range(0, 127)) - 64;
            end
            send_item(OP_SAMPLE, pot, enc, lat, pulses);
         end
      end
   endtask

   initial begin : stimulus
      int sent;
      int n;
      int eff;
      int base;
      logic [CSR_DATA_W-1:0] spacing;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: commands, saturating samples, half-way snaps both signs
      send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);
      send_item(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_FORCE_ERROR, $urandom, $urandom, $urandom, $urandom);
      send_item(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < 8; i++) begin
         base = int'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
         send_item(OP_SAMPLE, base + 32'sh0001_8000, base, $urandom, 32'd7);
      end
      base = int'($urandom_range(0, 32'h000F_FFFF));
      send_item(OP_SAMPLE, base + 32'sh0001_8000, base, 32'h0000_0000, 32'd8);
      send_item(OP_SAMPLE, base + 32'sh0001_8000, base, 32'hFFFD_0000, 32'd9);

      // directed: single-sample filter, widest spacing, snapped offset clamps
      wait_drained();
      write_settings(32'd0, 32'h7FFF_FFFF, 32'h0000_0000, 32'd0);
      send_item(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
      send_item(OP_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'd10);
      send_item(OP_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'd11);
      send_item(OP_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'd12);

      // directed: oversize filter length, zero spacing, state kept over the write
      wait_drained();
      write_settings(32'hABCD_EF3F, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_SAMPLE, $urandom, $urandom, $urandom, 32'd20);
      send_item(OP_SAMPLE, $urandom, $urandom, $urandom, 32'd21);
      send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);

      // random phases, each with its own settings and idling pattern
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            1: begin tx_idle_pct = 82; rx_stall_pct <= 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct <= 82; end
            default: begin tx_idle_pct = 14; rx_stall_pct <= 14; end
         endcase
         spacing = $urandom_range(1, 32'h0010_0000);
         case (ph)
            0: write_settings(32'd4, 32'd65536, 32'd0, 32'd32768);
            1: write_settings(32'd1, 32'd1, 32'h8000_0000, 32'd0);
            2: write_settings(32'd32, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            4: write_settings(32'd2, spacing + 32'h0002_0000, $urandom,
                              $urandom_range(0, spacing));
            6: write_settings(32'd63, spacing, $urandom, $urandom_range(0, 2 * spacing));
            default: write_settings($urandom_range(1, 8), spacing, $urandom,
                                    $urandom_range(0, spacing));
         endcase
         eff = board.effective_length();

         // receiver holds off while items keep coming, so the block backs up
         if (ph == 0) begin
            hold_len    <= HOLD_CYCLES;
            hold_toggle <= ~hold_toggle;
            run_track(10, 1'b1);
         end

         // first track carries the zeroed state over the filter length write
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            n = $urandom_range(eff + 4, 3 * eff + 20);
            run_track(n, sent != 0);
            sent += n;
            if ($urandom_range(7) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d samples, %0d forced errors, %0d restarts, %0d no-ops over eight settings",
               board.op_count[OP_SAMPLE], board.op_count[OP_FORCE_ERROR],
               board.op_count[OP_RESTART], board.op_count[OP_NONE]);
      $display("%0d responses checked: %0d index snaps, %0d zeroed, %0d with error raised",
               board.checked, board.snaps, board.zeroed_seen, board.error_seen);
      if (board.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
